FILE: hw/rtl/trinomial_tree_call_pricer_assert.svh
// assertion macros shared by the checker
`ifndef TRINOMIAL_TREE_CALL_PRICER_ASSERT_SVH
`define TRINOMIAL_TREE_CALL_PRICER_ASSERT_SVH
`define TTCP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TTCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hw/rtl/ttcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ttcp_pkg;
   localparam int MAX_STEPS = 256;
   localparam int NODE_COUNT = 2 * MAX_STEPS + 1;
   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int STEP_W = 9;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_STEPS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PU = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DISC = 3'd6;

   // datapath operations
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd1;  // cur <= spot
   localparam logic [2:0] OP_DOWN = 3'd2;  // cur <= cur*down
   localparam logic [2:0] OP_LEAF = 3'd3;  // write payoff at addr, cur <= cur*up
   localparam logic [2:0] OP_RD = 3'd4;    // read node at addr into window
   localparam logic [2:0] OP_NODE = 3'd5;  // compute node, write at addr
   localparam logic [2:0] OP_LAST = 3'd6;  // write last payoff at addr, no up move

   typedef struct packed {
      logic [2:0] op;
      logic [NODE_AW-1:0] addr;
      logic clear_sat;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
   } dp_stat_type;
endpackage
`default_nettype wire

FILE: hw/rtl/ttcp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ttcp_req_if;
   logic valid;
   logic ready;
   logic [31:0] spot;
   logic [31:0] strike;
   modport source (output valid, spot, strike, input ready);
   modport sink (input valid, spot, strike, output ready);
endinterface

interface ttcp_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] price;
   logic saturated;
   modport source (output valid, price, saturated, input ready);
   modport sink (input valid, price, saturated, output ready);
endinterface

interface ttcp_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ttcp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ttcp_datapath import ttcp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   input  wire logic [31:0] spot,
   input  wire logic [31:0] strike,
   input  wire logic [31:0] up_factor,
   input  wire logic [31:0] down_factor,
   input  wire logic [31:0] prob_up,
   input  wire logic [31:0] prob_mid,
   input  wire logic [31:0] prob_down,
   input  wire logic [31:0] discount,
   output dp_stat_type      stat,
   output logic [31:0]      root,
   output logic             sat
);
   // sequence per node: issue reads, three multiply stages, clamp, then discount multiply
   logic [31:0] mem [NODE_COUNT];
   logic [31:0] rd_ff;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] w0_ff, w1_ff, w2_ff;
   logic [2:0]  ph_ff, ph_in;
   logic [NODE_AW-1:0] waddr_ff, waddr_in;
   logic signed [65:0] acc_ff, acc_in;
   logic [31:0] wt_ff, wt_in;
   logic sat_ff, sat_in;
   logic rd_pend_ff;
   logic [31:0] root_ff;
   logic we;
   logic [31:0] wdata;

   function automatic logic [32:0] mulq(input logic [31:0] x, input logic [31:0] f);
      logic [63:0] p;
      logic [34:0] s;
      p = x * f;
      s = 35'((p + 64'(1 << 29)) >> 30);
      mulq = (s > 35'hFFFFFFFF) ? {1'b1, 32'hFFFFFFFF} : {1'b0, s[31:0]};
   endfunction

   logic [32:0] mq_cur, mq_out;
   logic [31:0] mulf;
   logic [31:0] mulx;
   // single shared unsigned 32x32 multiplier: for cur updates or discount
   assign mulx = (ph_ff == 3'd4) ? wt_ff : cur_ff;
   assign mulf = (ph_ff == 3'd4) ? discount :
                 (cmd.op == OP_DOWN) ? down_factor : up_factor;
   assign mq_cur = mulq(mulx, mulf);
   assign mq_out = mq_cur;

   // signed 33x32 term for weighting (value split hi/lo folds into one exact product)
   logic signed [32:0] tv;
   logic signed [31:0] tp;
   logic signed [64:0] term;
   always_comb begin
      case (ph_ff)
         3'd1: begin tv = $signed({1'b0, w0_ff}); tp = $signed(prob_down); end
         3'd2: begin tv = $signed({1'b0, w1_ff}); tp = $signed(prob_mid); end
         default: begin tv = $signed({1'b0, w2_ff}); tp = $signed(prob_up); end
      endcase
   end
   assign term = tv * tp;

   // floor((acc + 2^29) / 2^30) with clamp, sum of three terms needs 66 bits
   logic signed [66:0] rnd;
   logic signed [36:0] q;
   assign rnd = $signed({acc_ff[65], acc_ff}) + 67'sd536870912;
   assign q = 37'(rnd >>> 30);

   always_comb begin
      cur_in = cur_ff;
      ph_in = ph_ff;
      waddr_in = waddr_ff;
      acc_in = acc_ff;
      wt_in = wt_ff;
      sat_in = cmd.clear_sat ? 1'b0 : sat_ff;
      we = 1'b0;
      wdata = (cur_ff > strike) ? cur_ff - strike : 32'd0;
      case (ph_ff)
         3'd1: begin acc_in = 66'(term); ph_in = 3'd2; end
         3'd2: begin acc_in = acc_ff + 66'(term); ph_in = 3'd3; end
         3'd3: begin acc_in = acc_ff + 66'(term); ph_in = 3'd5; end
         3'd5: begin
            if (q < 0) begin wt_in = 32'd0; sat_in = 1'b1; end
            else if (q > 37'sh0FFFFFFFF) begin wt_in = 32'hFFFFFFFF; sat_in = 1'b1; end
            else wt_in = q[31:0];
            ph_in = 3'd4;
         end
         3'd4: begin
            we = 1'b1;
            wdata = mq_out[31:0];
            sat_in = sat_in | mq_out[32];
            ph_in = 3'd0;
         end
         default: begin
            case (cmd.op)
               OP_LOAD: cur_in = spot;
               OP_DOWN: begin cur_in = mq_cur[31:0]; sat_in = sat_in | mq_cur[32]; end
               OP_LEAF: begin
                  we = 1'b1;
                  cur_in = mq_cur[31:0];
                  sat_in = sat_in | mq_cur[32];
               end
               OP_LAST: we = 1'b1;
               OP_NODE: begin waddr_in = cmd.addr; ph_in = 3'd1; end
               default: ;
            endcase
         end
      endcase
   end

   logic [NODE_AW-1:0] wa;
   assign wa = (ph_ff == 3'd4) ? waddr_ff : cmd.addr;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wdata;
      rd_ff <= mem[cmd.addr];
      if (rd_pend_ff) begin
         w0_ff <= w1_ff; w1_ff <= w2_ff; w2_ff <= rd_ff;
      end
      if (we && wa == '0) root_ff <= wdata;
      cur_ff <= cur_in;
      acc_ff <= acc_in;
      wt_ff <= wt_in;
      waddr_ff <= waddr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 3'd0;
         sat_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         sat_ff <= sat_in;
         rd_pend_ff <= (cmd.op == OP_RD) && (ph_ff == 3'd0);
      end
   end

   assign stat.busy = (ph_ff != 3'd0) || rd_pend_ff;
   assign root = root_ff;
   assign sat = sat_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/ttcp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ttcp_ctrl import ttcp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              hold,
   input  wire logic [STEP_W-1:0] num_steps,
   input  wire dp_stat_type       stat,
   output dp_cmd_type             cmd,
   output logic                   done
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DOWN = 3'd1;
   localparam logic [2:0] S_LEAF = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_NODE = 3'd4;
   localparam logic [2:0] S_WAIT = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] st_ff, st_in;
   logic [STEP_W-1:0] n_ff, n_in, s_ff, s_in;
   logic [NODE_AW:0] i_ff, i_in;
   logic [1:0] r_ff, r_in;
   logic [STEP_W-1:0] nclip;
   assign nclip = (num_steps > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : num_steps;

   always_comb begin
      st_in = st_ff; n_in = n_ff; s_in = s_ff; i_in = i_ff; r_in = r_ff;
      cmd.op = OP_NONE; cmd.addr = i_ff[NODE_AW-1:0]; cmd.clear_sat = 1'b0;
      done = 1'b0;
      case (st_ff)
         S_IDLE: if (start) begin
            cmd.op = OP_LOAD; cmd.clear_sat = 1'b1;
            n_in = nclip; s_in = nclip; i_in = '0;
            st_in = (nclip == '0) ? S_LEAF : S_DOWN;
         end
         S_DOWN: begin
            cmd.op = OP_DOWN;
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == (NODE_AW+1)'(n_ff)) begin i_in = '0; st_in = S_LEAF; end
         end
         S_LEAF: begin
            cmd.op = OP_LEAF;
            i_in = i_ff + 1'b1;
            if (i_ff == (NODE_AW+1)'({n_ff, 1'b0})) begin
               // last leaf takes no further up move
               cmd.op = OP_LAST;
               i_in = '0; r_in = '0;
               st_in = (s_ff == '0) ? S_DONE : S_RD;
            end
         end
         S_RD: if (!stat.busy) begin
            // prime window with nodes i, i+1, i+2, one read once the datapath is idle
            cmd.op = OP_RD;
            cmd.addr = NODE_AW'(i_ff + r_ff);
            r_in = r_ff + 1'b1;
            if (r_ff == 2'd2) st_in = S_WAIT;
         end
         S_WAIT: if (!stat.busy) st_in = S_NODE;
         S_NODE: begin
            cmd.op = OP_NODE;
            i_in = i_ff + 1'b1;
            r_in = 2'd2;
            if (i_ff + 1'b1 == (NODE_AW+1)'({s_ff, 1'b0} - 1'b1)) begin
               i_in = '0; r_in = '0; s_in = s_ff - 1'b1;
               st_in = (s_ff == STEP_W'(1)) ? S_DONE : S_RD;
            end else st_in = S_RD;
         end
         S_DONE: if (!stat.busy && !hold) begin done = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; n_ff <= '0; s_ff <= '0; i_ff <= '0; r_ff <= '0;
      end else begin
         st_ff <= st_in; n_ff <= n_in; s_ff <= s_in; i_ff <= i_in; r_ff <= r_in;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/trinomial_tree_call_pricer.sv
`timescale 1ns / 1ps
`default_nettype none
// trinomial call pricer: one transaction in gives one price out. with n steps
// (clipped to 256) an item takes n down moves, 2n+1 leaf writes and n*n
// backward nodes, paced by the single node memory port and the shared multiplier
// in the datapath. the result sits in an output register, so the next
// transaction is accepted while it waits; that item finishes only once the
// register has been taken.
module trinomial_tree_call_pricer import ttcp_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   ttcp_req_if.sink   req,
   ttcp_rsp_if.source rsp,
   ttcp_csr_if.sink   csr
);
   logic [STEP_W-1:0] num_steps_ff;
   logic [31:0] up_ff, down_ff, pu_ff, pm_ff, pd_ff, disc_ff;
   logic [31:0] spot_ff, strike_ff;
   logic busy_ff, rsp_v_ff;
   logic [31:0] price_ff;
   logic sat_out_ff;
   logic start, done, dsat;
   logic out_hold;
   logic [31:0] root;
   dp_cmd_type cmd;
   dp_stat_type stat;

   assign csr.ready = 1'b1;
   assign req.ready = !busy_ff;
   assign start = req.valid && req.ready;
   assign rsp.valid = rsp_v_ff;
   assign rsp.price = price_ff;
   assign rsp.saturated = sat_out_ff;
   // finished item waits while the previous result is still held
   assign out_hold = rsp_v_ff && !rsp.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_steps_ff <= STEP_W'(1);
         up_ff <= 32'h40000000; down_ff <= 32'h40000000;
         pu_ff <= '0; pm_ff <= 32'h40000000; pd_ff <= '0;
         disc_ff <= 32'h40000000;
      end else if (csr.valid) begin
         case (csr.index)
            REG_NUM_STEPS: num_steps_ff <= csr.data[STEP_W-1:0];
            REG_UP: up_ff <= csr.data;
            REG_DOWN: down_ff <= csr.data;
            REG_PU: pu_ff <= csr.data;
            REG_PM: pm_ff <= csr.data;
            REG_PD: pd_ff <= csr.data;
            REG_DISC: disc_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // operand capture and result hold
   always_ff @(posedge clock) begin
      if (start) begin spot_ff <= req.spot; strike_ff <= req.strike; end
      if (done) begin price_ff <= root; sat_out_ff <= dsat; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; rsp_v_ff <= 1'b0;
      end else begin
         if (start) busy_ff <= 1'b1;
         else if (done) busy_ff <= 1'b0;
         if (done) rsp_v_ff <= 1'b1;
         else if (rsp.ready) rsp_v_ff <= 1'b0;
      end
   end

   // controller starts in the cycle after capture so operands are registered
   logic go_ff;
   always_ff @(posedge clock) begin
      if (reset) go_ff <= 1'b0;
      else go_ff <= start;
   end

   ttcp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(go_ff), .hold(out_hold),
      .num_steps(num_steps_ff), .stat(stat), .cmd(cmd), .done(done)
   );

   ttcp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .spot(spot_ff), .strike(strike_ff),
      .up_factor(up_ff), .down_factor(down_ff), .prob_up(pu_ff), .prob_mid(pm_ff),
      .prob_down(pd_ff), .discount(disc_ff), .stat(stat), .root(root), .sat(dsat)
   );
endmodule
`default_nettype wire

FILE: hw/rtl/ttcp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "trinomial_tree_call_pricer_assert.svh"
module ttcp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [31:0] rsp_price,
   input wire logic rsp_saturated
);
   // held result keeps its saturation flag
   `TTCP_ASSERT_NEXT(sat_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_saturated))
   // accepted item blocks further accepts
   `TTCP_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // held result stays put
   `TTCP_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_price))
endmodule

bind trinomial_tree_call_pricer ttcp_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_price(rsp.price),
   .rsp_saturated(rsp.saturated)
);
`default_nettype wire

FILE: dv/trinomial_tree_call_pricer_tb.sv
`timescale 1ns / 1ps
module trinomial_tree_call_pricer_tb;
   import ttcp_pkg::*;

   // index past the last register, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct {
      logic [31:0] price;
      logic        saturated;
   } call_quote_type;

   // tree pricer model plus the queue of quotes still owed by the block
   class call_price_board;
      logic [8:0]  steps;
      logic [31:0] up_f, down_f, p_up, p_mid, p_down, disc;
      logic [31:0] nodes [NODE_COUNT];
      call_quote_type owed [$];
      int          errors;

      function void reset_regs();
         steps = 9'd1;
         up_f = ONE_Q30;
         down_f = ONE_Q30;
         p_up = 32'd0;
         p_mid = ONE_Q30;
         p_down = 32'd0;
         disc = ONE_Q30;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            REG_NUM_STEPS: steps = val[8:0];
            REG_UP:        up_f = val;
            REG_DOWN:      down_f = val;
            REG_PU:        p_up = val;
            REG_PM:        p_mid = val;
            REG_PD:        p_down = val;
            REG_DISC:      disc = val;
            default: ;
         endcase
      endfunction

      // price times q2.30 factor, round half up, clamp high
      function logic [31:0] scale(logic [31:0] x, logic [31:0] f, inout logic sat);
         logic [63:0] p;
         p = (64'(x) * 64'(f) + 64'(1 << 29)) >> 30;
         if (p > 64'(ALL_ONES)) begin
            sat = 1'b1;
            return ALL_ONES;
         end
         return p[31:0];
      endfunction

      // three-way weighted sum, rounded half up, clamped to unsigned 32 bits
      function logic [31:0] blend(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                                  inout logic sat);
         longint wu, wm, wd, hi, lo, r;
         wu = longint'(signed'(p_up));
         wm = longint'(signed'(p_mid));
         wd = longint'(signed'(p_down));
         hi = wd * longint'(v0[31:16]) + wm * longint'(v1[31:16]) + wu * longint'(v2[31:16]);
         lo = wd * longint'(v0[15:0]) + wm * longint'(v1[15:0]) + wu * longint'(v2[15:0]);
         r = (hi + (lo >>> 16) + 8192) >>> 14;
         if (r < 0) begin
            sat = 1'b1;
            return 32'd0;
         end
         if (r > longint'(ALL_ONES)) begin
            sat = 1'b1;
            return ALL_ONES;
         end
         return r[31:0];
      endfunction

      function void note_option(logic [31:0] spot, logic [31:0] strike);
         int n, leaves;
         logic [31:0] cur;
         logic [31:0] w;
         logic sat;
         call_quote_type q;
         n = (steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
         leaves = 2 * n + 1;
         sat = 1'b0;
         cur = spot;
         for (int i = 0; i < n; i++) cur = scale(cur, down_f, sat);
         for (int i = 0; i < leaves; i++) begin
            nodes[i] = (cur > strike) ? cur - strike : 32'd0;
            if (i + 1 < leaves) cur = scale(cur, up_f, sat);
         end
         for (int s = n; s > 0; s--)
            for (int i = 0; i < 2 * s - 1; i++) begin
               w = blend(nodes[i], nodes[i+1], nodes[i+2], sat);
               nodes[i] = scale(w, disc, sat);
            end
         q.price = nodes[0];
         q.saturated = sat;
         owed = {owed, q};
      endfunction

      function void check_quote(logic [31:0] price, logic saturated);
         call_quote_type q;
         if (owed.size() == 0) begin
            $error("unexpected price transaction: price %h saturated %b", price, saturated);
            errors++;
            return;
         end
         q = owed.pop_front();
         if (price !== q.price) begin
            $error("price: expected %h actual %h", q.price, price);
            errors++;
         end
         if (saturated !== q.saturated) begin
            $error("saturated: expected %b actual %b", q.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   ttcp_req_if req ();
   ttcp_rsp_if rsp ();
   ttcp_csr_if csr ();

   call_price_board board;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   longint cycles;

   trinomial_tree_call_pricer u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog on total run length
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("trinomial_tree_call_pricer test failed");
         $finish;
      end
   end

   // result side: check each accepted transaction, then pick next ready
   initial begin
      int hold_left;
      hold_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) board.check_quote(rsp.price, rsp.saturated);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            // long back-pressure stretch so a finished item backs up behind the result
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      board.write_reg(idx, val);
      csr.valid <= 1'b0;
   endtask

   // offer one option; valid stays up across back-to-back transactions
   task automatic send_option(logic [31:0] spot, logic [31:0] strike);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.spot <= spot;
      req.strike <= strike;
      do @(posedge clock); while (!req.ready);
      board.note_option(spot, strike);
   endtask

   // block is idle once nothing is owed; pad a little for the last write-back
   task automatic drain();
      req.valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_tree(logic [8:0] n, logic [31:0] up, logic [31:0] dn, logic [31:0] pu,
                            logic [31:0] pm, logic [31:0] pd, logic [31:0] dc);
      write_csr(REG_NUM_STEPS, {23'd0, n});
      write_csr(REG_UP, up);
      write_csr(REG_DOWN, dn);
      write_csr(REG_PU, pu);
      write_csr(REG_PM, pm);
      write_csr(REG_PD, pd);
      write_csr(REG_DISC, dc);
   endtask

   // market-like tree: small up/down spread, probabilities summing to one
   task automatic load_market_tree(logic [8:0] n);
      logic [31:0] pu, pd;
      pu = $urandom_range(32'h1000_0000, 32'h0800_0000);
      pd = $urandom_range(32'h1000_0000, 32'h0800_0000);
      load_tree(n, ONE_Q30 + $urandom_range(32'h0800_0000, 0),
                $urandom_range(ONE_Q30, 32'h3800_0000), pu, ONE_Q30 - pu - pd, pd,
                $urandom_range(ONE_Q30, 32'h3F00_0000));
   endtask

   initial begin
      logic [31:0] s;
      board = new();
      board.reset_regs();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.spot <= '0;
      req.strike <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset tree: one step, identity factors, price is plain intrinsic value
      send_option(32'd0, 32'd0);
      send_option(ALL_ONES, 32'd0);
      send_option(32'd0, ALL_ONES);
      send_option(ALL_ONES, ALL_ONES);
      send_option(32'h0064_0000, 32'h0050_0000);
      send_option(32'h0050_0000, 32'h0064_0000);
      drain();

      // zero steps gives a single leaf
      write_csr(REG_NUM_STEPS, 32'd0);
      send_option(ALL_ONES, 32'd1);
      send_option(32'd5, 32'd5);
      drain();

      // huge factors saturate the leaf walk, later up moves run on all ones
      load_tree(9'd2, ALL_ONES, ALL_ONES, ONE_Q30, ONE_Q30, ONE_Q30, ALL_ONES);
      send_option(32'h1000_0000, 32'd0);
      send_option(ALL_ONES, 32'd0);
      drain();

      // most negative weights drive the blend below zero and clamp it
      load_tree(9'd3, 32'h4800_0000, 32'h3800_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'd0);
      write_csr(REG_SPARE, 32'h0000_0001);
      send_option(32'h0100_0000, 32'h0080_0000);
      drain();
      write_csr(REG_PU, 32'h7FFF_FFFF);
      send_option(32'h0100_0000, 32'h0080_0000);
      drain();

      // step count beyond the maximum is clipped: one full-depth option only
      load_market_tree(9'h1FF);
      send_option(32'h0064_0000, 32'h0064_0000);
      drain();

      // random phases, idle pattern rotates: none, sender, receiver, both
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         if (ph % 3 == 2)
            load_tree($urandom_range(8, 0), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
         else
            load_market_tree($urandom_range(8, 1));
         if (ph == 0) hold_request = 3000;
         for (int k = 0; k < 13; k++) begin
            case ($urandom_range(3))
               0: send_option($urandom, $urandom);
               default: begin
                  // spot near strike so the payoff edge is exercised
                  s = $urandom_range(32'h0100_0000, 32'h0010_0000);
                  send_option(s, s + $urandom_range(32'h0008_0000, 0) - 32'h0004_0000);
               end
            endcase
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("trinomial_tree_call_pricer test passed");
      end else begin
         $display("trinomial_tree_call_pricer test failed");
      end
      $finish;
   end
endmodule
